FILE: hw/rtl/usbpd_pkg.sv
package usbpd_pkg;

  // Packet limits and counter width
  localparam int unsigned MAX_PACKET_BYTES = 2047;
  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

  // Configuration register indexes
  localparam logic CFG_FULL_SPEED = 1'b0;
  localparam logic CFG_IDLE_LEVEL = 1'b1;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Error flag bit positions
  localparam int unsigned ERR_STUFF   = 0;
  localparam int unsigned ERR_PARTIAL = 1;
  localparam int unsigned ERR_SIZE    = 2;
  localparam int unsigned ERR_SYNC    = 3;
  localparam int unsigned ERR_PID     = 4;
  localparam int unsigned ERR_CRC     = 5;

  // Sync patterns
  localparam logic [7:0] SYNC_FULL = 8'h80;
  localparam logic [7:0] SYNC_LOW  = 8'h81;

  // PID codes (low nibble)
  localparam logic [3:0] PID_OUT        = 4'h1;
  localparam logic [3:0] PID_IN         = 4'h9;
  localparam logic [3:0] PID_SOF        = 4'h5;
  localparam logic [3:0] PID_CTRL_SETUP = 4'hd;
  localparam logic [3:0] PID_HS_PING    = 4'h4;
  localparam logic [3:0] PID_HUB_SPLIT  = 4'h8;
  localparam logic [3:0] PID_DAT0       = 4'h3;
  localparam logic [3:0] PID_DAT1       = 4'hb;
  localparam logic [3:0] PID_DAT2       = 4'h7;
  localparam logic [3:0] PID_DATM       = 4'hf;
  localparam logic [3:0] PID_RSVD       = 4'h0;

  // CRC seeds and good residuals
  localparam logic [7:0]  CRC5_INIT   = 8'hff;
  localparam logic [7:0]  CRC5_GOOD   = 8'h09;
  localparam logic [15:0] CRC16_INIT  = 16'hffff;
  localparam logic [15:0] CRC16_GOOD  = 16'hb001;
  localparam logic [15:0] CRC16_POLY  = 16'ha001;

  // Stuffed bit follows this many ones
  localparam logic [2:0] STUFF_RUN = 3'd6;

  localparam logic [7:0] CRC5_BASIS [8] = '{
    8'h0e, 8'h1c, 8'h11, 8'h0b, 8'h16, 8'h05, 8'h0a, 8'h14
  };

  typedef struct packed {
    logic line_level;
    logic end_of_packet;
  } bit_item_t;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       data_byte;
    logic [5:0]       error_flags;
    logic [CNT_W-1:0] packet_bytes;
    logic [3:0]       packet_pid;
    logic             last_of_run;
  } result_item_t;

  // Token CRC5 over one byte, as a sum of basis rows
  function automatic logic [7:0] crc5_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) r = r ^ CRC5_BASIS[i];
    end
    return r;
  endfunction

  // Data CRC16 over one byte, reflected form
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/usb_packet_bit_decoder.sv
// A result enters the result queue in the cycle after the bit that causes it is accepted.
// Throughput: one line bit per cycle; a bit may cause a byte and a status together, which a
//   four-entry result queue absorbs, so bit_ready drops only when the queue holds three or more.
// Reset (rst, synchronous): full_speed and idle_level return to 1, all packet state clears and
//   the result queue empties.
module usb_packet_bit_decoder import usbpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic         cfg_data,
  input  logic         bit_valid,
  output logic         bit_ready,
  input  bit_item_t    bit_data,
  output logic         res_valid,
  input  logic         res_ready,
  output result_item_t res_data
);

  // Configuration and packet state
  logic             full_speed;
  logic             idle_level;
  logic             previous_level;
  logic [2:0]       ones_run;
  logic [2:0]       bit_position;
  logic [7:0]       byte_accumulator;
  logic [CNT_W-1:0] byte_counter;
  logic [7:0]       sync_value;
  logic [7:0]       pid_value;
  logic [7:0]       crc5_running;
  logic [15:0]      crc16_running;
  logic [5:0]       error_accum;

  // Result queue
  result_item_t fifo [4];
  logic [1:0]   head;
  logic [1:0]   tail;
  logic [2:0]   fifo_count;

  logic             take;
  logic             pop;
  logic             dbit;
  logic             stuffed;
  logic [7:0]       acc_new;
  logic             byte_done;
  logic [2:0]       bitpos_next;
  logic [2:0]       ones_next;
  logic [CNT_W-1:0] cnt_next;
  logic [7:0]       sync_next;
  logic [7:0]       pid_next;
  logic [7:0]       crc5_next;
  logic [15:0]      crc16_next;
  logic [5:0]       err_next;
  logic [5:0]       st_err;
  logic [3:0]       st_pid;
  logic             token_pid;
  logic             data_pid;
  result_item_t     byte_item;
  result_item_t     status_item;
  logic [1:0]       push_n;

  assign take      = bit_valid && bit_ready;
  assign pop       = res_valid && res_ready;
  assign bit_ready = (fifo_count <= 3'd2);
  assign res_valid = (fifo_count != 3'd0);
  assign res_data  = fifo[head];

  // Decode NRZI, drop stuffed bits and assemble bytes
  always_comb begin
    dbit        = (bit_data.line_level == previous_level);
    stuffed     = (ones_run >= STUFF_RUN);
    acc_new     = byte_accumulator | (8'(dbit) << bit_position);
    byte_done   = !stuffed && (bit_position == 3'd7);
    bitpos_next = stuffed ? bit_position : bit_position + 3'd1;
    ones_next   = stuffed ? 3'd0 : (dbit ? ones_run + 3'd1 : 3'd0);
    err_next    = error_accum;
    if (stuffed && dbit) err_next[ERR_STUFF] = 1'b1;
    cnt_next   = byte_counter;
    sync_next  = sync_value;
    pid_next   = pid_value;
    crc5_next  = crc5_running;
    crc16_next = crc16_running;
    if (byte_done) begin
      if (byte_counter == CNT_W'(0)) begin
        sync_next = acc_new;
      end else if (byte_counter == CNT_W'(1)) begin
        pid_next = acc_new;
      end else begin
        crc5_next  = crc5_byte(crc5_running, acc_new);
        crc16_next = crc16_byte(crc16_running, acc_new);
      end
      if (byte_counter < CNT_W'(MAX_PACKET_BYTES)) cnt_next = byte_counter + CNT_W'(1);
    end
  end

  // Check the finished packet
  always_comb begin
    st_err    = err_next;
    st_pid    = '0;
    token_pid = (pid_next[3:0] == PID_OUT) || (pid_next[3:0] == PID_IN) ||
                (pid_next[3:0] == PID_SOF) || (pid_next[3:0] == PID_CTRL_SETUP) ||
                (pid_next[3:0] == PID_HS_PING) || (pid_next[3:0] == PID_HUB_SPLIT);
    data_pid  = (pid_next[3:0] == PID_DAT0) || (pid_next[3:0] == PID_DAT1) ||
                (pid_next[3:0] == PID_DAT2) || (pid_next[3:0] == PID_DATM);
    if (bitpos_next != 3'd0) st_err[ERR_PARTIAL] = 1'b1;
    if (cnt_next == CNT_W'(0)) begin
      st_err[ERR_SIZE] = 1'b1;
    end else begin
      if (sync_next != (full_speed ? SYNC_FULL : SYNC_LOW)) st_err[ERR_SYNC] = 1'b1;
      if (cnt_next == CNT_W'(1)) begin
        st_err[ERR_SIZE] = 1'b1;
      end else begin
        st_pid = pid_next[3:0];
        if ((pid_next[3:0] != ~pid_next[7:4]) || (pid_next[3:0] == PID_RSVD)) begin
          st_err[ERR_PID] = 1'b1;
        end
        if (token_pid) begin
          if ((pid_next[3:0] == PID_HUB_SPLIT) ? (cnt_next != CNT_W'(5))
                                               : (cnt_next != CNT_W'(4))) begin
            st_err[ERR_SIZE] = 1'b1;
          end else if (crc5_next != CRC5_GOOD) begin
            st_err[ERR_CRC] = 1'b1;
          end
        end else if (data_pid) begin
          if (cnt_next < CNT_W'(4)) begin
            st_err[ERR_SIZE] = 1'b1;
          end else if (crc16_next != CRC16_GOOD) begin
            st_err[ERR_CRC] = 1'b1;
          end
        end
      end
    end
  end

  // Build result transactions
  always_comb begin
    byte_item              = '0;
    byte_item.item_kind    = KIND_BYTE;
    byte_item.data_byte    = acc_new;
    byte_item.last_of_run  = !bit_data.end_of_packet;
    status_item              = '0;
    status_item.item_kind    = KIND_STATUS;
    status_item.error_flags  = st_err;
    status_item.packet_bytes = cnt_next;
    status_item.packet_pid   = st_pid;
    status_item.last_of_run  = 1'b1;
    push_n = '0;
    if (take) push_n = 2'(byte_done) + 2'(bit_data.end_of_packet);
  end

  // Write queue entries
  always_ff @(posedge clk) begin
    if (take && byte_done) begin
      fifo[tail] <= byte_item;
      if (bit_data.end_of_packet) fifo[tail + 2'd1] <= status_item;
    end else if (take && bit_data.end_of_packet) begin
      fifo[tail] <= status_item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fifo_count <= '0;
    end else begin
      tail       <= tail + push_n;
      if (pop) head <= head + 2'd1;
      fifo_count <= fifo_count + 3'(push_n) - 3'(pop);
    end
  end

  // Hold configuration and packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed       <= 1'b1;
      idle_level       <= 1'b1;
      previous_level   <= 1'b1;
      ones_run         <= '0;
      bit_position     <= '0;
      byte_accumulator <= '0;
      byte_counter     <= '0;
      sync_value       <= '0;
      pid_value        <= '0;
      crc5_running     <= CRC5_INIT;
      crc16_running    <= CRC16_INIT;
      error_accum      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FULL_SPEED: full_speed <= cfg_data;
          CFG_IDLE_LEVEL: begin
            idle_level     <= cfg_data;
            previous_level <= cfg_data;
          end
          default: ;
        endcase
      end
      if (take) begin
        if (bit_data.end_of_packet) begin
          previous_level   <= idle_level;
          ones_run         <= '0;
          bit_position     <= '0;
          byte_accumulator <= '0;
          byte_counter     <= '0;
          sync_value       <= '0;
          pid_value        <= '0;
          crc5_running     <= CRC5_INIT;
          crc16_running    <= CRC16_INIT;
          error_accum      <= '0;
        end else begin
          previous_level   <= bit_data.line_level;
          ones_run         <= ones_next;
          bit_position     <= bitpos_next;
          byte_accumulator <= byte_done ? 8'h00 : (stuffed ? byte_accumulator : acc_new);
          byte_counter     <= cnt_next;
          sync_value       <= sync_next;
          pid_value        <= pid_next;
          crc5_running     <= crc5_next;
          crc16_running    <= crc16_next;
          error_accum      <= err_next;
        end
      end
    end
  end

  // Queue never overflows its four entries
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst) fifo_count <= 3'd4)
    else $error("result queue overflow");

  // Ones run never passes the stuffing point
  a_run_bound: assert property (@(posedge clk) disable iff (rst) ones_run <= STUFF_RUN)
    else $error("ones run beyond stuffing point");

  // End of packet clears the byte assembly
  a_eop_clear: assert property (@(posedge clk) disable iff (rst)
    take && bit_data.end_of_packet |=> (bit_position == 3'd0) && (byte_counter == CNT_W'(0)))
    else $error("packet state not cleared after end of packet");

  // End of packet always queues a status entry
  a_eop_status: assert property (@(posedge clk) disable iff (rst)
    take && bit_data.end_of_packet |=> fifo_count >= $past(fifo_count))
    else $error("status transaction not queued");

endmodule

FILE: test/usb_packet_bit_decoder_tb.sv
`timescale 1ns / 1ps

module usb_packet_bit_decoder_tb;
  import usbpd_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BITS = 150;
  localparam logic [3:0] PID_ACK = 4'h2;

  localparam logic [3:0] TOKEN_PIDS [6] = '{PID_OUT, PID_IN, PID_SOF, PID_CTRL_SETUP,
                                            PID_HS_PING, PID_HUB_SPLIT};
  localparam logic [3:0] DATA_PIDS [4] = '{PID_DAT0, PID_DAT1, PID_DAT2, PID_DATM};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_write = 1'b0;
  logic         cfg_index = CFG_FULL_SPEED;
  logic         cfg_data = 1'b0;
  logic         bit_valid = 1'b0;
  logic         bit_ready;
  bit_item_t    bit_data = '0;
  logic         res_valid;
  logic         res_ready = 1'b0;
  result_item_t res_data;

  usb_packet_bit_decoder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bit_valid(bit_valid),
    .bit_ready(bit_ready),
    .bit_data(bit_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder copy: configuration and per-packet state
  logic             full_speed_cfg;
  logic             idle_level_cfg;
  logic             last_level;
  logic [2:0]       ones_seen;
  logic [2:0]       bit_slot;
  logic [7:0]       byte_build;
  logic [CNT_W-1:0] bytes_seen;
  logic [7:0]       sync_seen;
  logic [7:0]       pid_seen;
  logic [7:0]       crc5_state;
  logic [15:0]      crc16_state;
  logic [5:0]       fault_bits;
  result_item_t     decoded_q[$];

  // Line encoder state for building stimulus
  logic [7:0] frame[$];
  bit         line_q[$];
  logic       enc_level;
  int         enc_ones;
  bit         stuff_fault = 1'b0;
  int         bits_sent = 0;

  // Handshake control
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int rx_wait = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  function automatic logic [7:0] crc5_next(input logic [7:0] state, input logic [7:0] data);
    logic [7:0] mix;
    logic [7:0] acc;
    mix = state ^ data;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (mix[k]) acc = acc ^ CRC5_BASIS[k];
    end
    return acc;
  endfunction

  function automatic logic [15:0] crc16_next(input logic [15:0] state, input logic [7:0] data);
    logic [15:0] acc;
    acc = state ^ {8'h00, data};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC16_POLY) : (acc >> 1);
    return acc;
  endfunction

  function automatic logic [7:0] sync_pattern(input logic fast);
    return fast ? SYNC_FULL : SYNC_LOW;
  endfunction

  task automatic clear_decode;
    last_level  = idle_level_cfg;
    ones_seen   = '0;
    bit_slot    = '0;
    byte_build  = '0;
    bytes_seen  = '0;
    sync_seen   = '0;
    pid_seen    = '0;
    crc5_state  = CRC5_INIT;
    crc16_state = CRC16_INIT;
    fault_bits  = '0;
  endtask

  task automatic reset_decode;
    full_speed_cfg = 1'b1;
    idle_level_cfg = 1'b1;
    clear_decode();
  endtask

  // Latch sync and pid, run both CRCs over the rest, count with saturation
  task automatic absorb_byte(input logic [7:0] v);
    if (bytes_seen == 0) sync_seen = v;
    else if (bytes_seen == 1) pid_seen = v;
    else begin
      crc5_state  = crc5_next(crc5_state, v);
      crc16_state = crc16_next(crc16_state, v);
    end
    if (bytes_seen < MAX_PACKET_BYTES) bytes_seen = bytes_seen + 1'b1;
  endtask

  function automatic logic [5:0] packet_verdict(output logic [3:0] pid_nib);
    logic [5:0] flags;
    logic [3:0] pid_lo;
    flags = fault_bits;
    pid_nib = '0;
    if (bit_slot != 0) flags[ERR_PARTIAL] = 1'b1;
    if (bytes_seen == 0) begin
      flags[ERR_SIZE] = 1'b1;
      return flags;
    end
    if (sync_seen != sync_pattern(full_speed_cfg)) flags[ERR_SYNC] = 1'b1;
    if (bytes_seen == 1) begin
      flags[ERR_SIZE] = 1'b1;
      return flags;
    end
    pid_lo = pid_seen[3:0];
    pid_nib = pid_lo;
    if (pid_lo != ~pid_seen[7:4] || pid_lo == PID_RSVD) flags[ERR_PID] = 1'b1;
    case (pid_lo)
      PID_OUT, PID_IN, PID_SOF, PID_CTRL_SETUP, PID_HS_PING, PID_HUB_SPLIT: begin
        if (bytes_seen != ((pid_lo == PID_HUB_SPLIT) ? 5 : 4)) flags[ERR_SIZE] = 1'b1;
        else if (crc5_state != CRC5_GOOD) flags[ERR_CRC] = 1'b1;
      end
      PID_DAT0, PID_DAT1, PID_DAT2, PID_DATM: begin
        if (bytes_seen < 4) flags[ERR_SIZE] = 1'b1;
        else if (crc16_state != CRC16_GOOD) flags[ERR_CRC] = 1'b1;
      end
      default: ;
    endcase
    return flags;
  endfunction

  // Decode one accepted line bit and queue the results it causes
  task automatic decode_line_bit(input logic level, input logic mark);
    logic         one;
    logic [3:0]   pid_nib;
    result_item_t r;
    one = (level == last_level);
    last_level = level;
    if (ones_seen >= STUFF_RUN) begin
      if (one) fault_bits[ERR_STUFF] = 1'b1;
      ones_seen = '0;
    end else begin
      ones_seen = one ? ones_seen + 3'd1 : 3'd0;
      byte_build[bit_slot] = one;
      bit_slot = bit_slot + 3'd1;
      if (bit_slot == 3'd0) begin
        absorb_byte(byte_build);
        r = '0;
        r.item_kind = KIND_BYTE;
        r.data_byte = byte_build;
        r.last_of_run = !mark;
        decoded_q.push_back(r);
        byte_build = '0;
      end
    end
    if (mark) begin
      r = '0;
      r.item_kind = KIND_STATUS;
      r.error_flags = packet_verdict(pid_nib);
      r.packet_pid = pid_nib;
      r.packet_bytes = bytes_seen;
      r.last_of_run = 1'b1;
      decoded_q.push_back(r);
      clear_decode();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    result_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing predicted", res_data));
      end else begin
        want = decoded_q.pop_front();
        compare_field("item_kind", res_data.item_kind, want.item_kind);
        compare_field("data_byte", res_data.data_byte, want.data_byte);
        compare_field("error_flags", res_data.error_flags, want.error_flags);
        compare_field("packet_bytes", res_data.packet_bytes, want.packet_bytes);
        compare_field("packet_pid", res_data.packet_pid, want.packet_pid);
        compare_field("last_of_run", res_data.last_of_run, want.last_of_run);
      end
    end
  end

  // Receiver: long hold on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      rx_wait <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      res_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_wait <= $urandom_range(0, 7);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Abort when neither side has moved a transaction for too long
  always @(posedge clk) begin
    if ((bit_valid && bit_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one line bit, hold until accepted, then predict
  task automatic send_bit(input logic level, input logic mark);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      bit_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    bit_valid <= 1'b1;
    bit_data <= '{line_level: level, end_of_packet: mark};
    do @(posedge clk); while (!bit_ready);
    decode_line_bit(level, mark);
    bits_sent++;
  endtask

  task automatic send_line(input bit mark_last);
    bit b;
    while (line_q.size() != 0) begin
      b = line_q.pop_front();
      send_bit(b, mark_last && line_q.size() == 0);
    end
  endtask

  // NRZI encode one data bit, inserting a stuffed bit after six ones (a transition unless stuff_fault)
  task automatic put_bit(input bit b);
    if (!b) enc_level = ~enc_level;
    line_q.push_back(enc_level);
    enc_ones = b ? enc_ones + 1 : 0;
    if (enc_ones == STUFF_RUN) begin
      if (stuff_fault) stuff_fault = 1'b0;
      else enc_level = ~enc_level;
      line_q.push_back(enc_level);
      enc_ones = 0;
    end
  endtask

  task automatic put_frame_bits(input int from, input int upto);
    for (int i = from; i < upto; i++) put_bit(frame[i / 8][i % 8]);
  endtask

  task automatic start_packet;
    enc_level = idle_level_cfg;
    enc_ones = 0;
    line_q.delete();
  endtask

  task automatic send_frame(input int extra_bits);
    start_packet();
    put_frame_bits(0, frame.size() * 8);
    repeat (extra_bits) put_bit(1'($urandom_range(0, 1)));
    if (line_q.size() == 0) put_bit(1'($urandom_range(0, 1)));
    send_line(1'b1);
    stuff_fault = 1'b0;
  endtask

  task automatic begin_frame(input logic [3:0] pid);
    frame.delete();
    frame.push_back(sync_pattern(full_speed_cfg));
    frame.push_back({~pid, pid});
  endtask

  // Token: random address bytes, last byte chosen to give the good residual
  task automatic build_token(input logic [3:0] pid);
    logic [7:0] c;
    begin_frame(pid);
    c = CRC5_INIT;
    repeat ((pid == PID_HUB_SPLIT) ? 2 : 1) begin
      frame.push_back(8'($urandom_range(0, 255)));
      c = crc5_next(c, frame[frame.size() - 1]);
    end
    for (int v = 0; v < 256; v++) begin
      if (crc5_next(c, v[7:0]) == CRC5_GOOD) begin
        frame.push_back(v[7:0]);
        break;
      end
    end
  endtask

  // Data: payload (random, mixed with 0xff, or all 0xff) and inverted CRC16
  task automatic build_data(input logic [3:0] pid, input int len, input int fill);
    logic [15:0] c;
    logic [7:0]  d;
    begin_frame(pid);
    c = CRC16_INIT;
    repeat (len) begin
      if (fill == 2 || (fill == 1 && $urandom_range(0, 1) == 1)) d = 8'hff;
      else d = 8'($urandom_range(0, 255));
      frame.push_back(d);
      c = crc16_next(c, d);
    end
    c = ~c;
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
  endtask

  task automatic build_other(input logic [3:0] pid, input int len);
    begin_frame(pid);
    repeat (len) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // Stop the sender, drain predictions and let the pipeline empty
  task automatic settle;
    bit_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_FULL_SPEED) begin
      full_speed_cfg = val;
    end else begin
      idle_level_cfg = val;
      last_level = val;
    end
    @(posedge clk);
  endtask

  task automatic test_short_packets;
    // nothing decoded, lone sync, lone bad sync with stray bits, single bit
    frame.delete();
    send_frame(3);
    frame.delete();
    frame.push_back(sync_pattern(full_speed_cfg));
    send_frame(0);
    frame.delete();
    frame.push_back(8'h00);
    send_frame(5);
    frame.delete();
    send_frame(0);
  endtask

  task automatic test_token_packets;
    foreach (TOKEN_PIDS[i]) begin
      build_token(TOKEN_PIDS[i]);
      send_frame(0);
    end
    // bad residual, then wrong size
    build_token(PID_IN);
    frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h10;
    send_frame(0);
    build_token(PID_CTRL_SETUP);
    frame.push_back(8'h5a);
    send_frame(0);
  endtask

  task automatic test_data_packets;
    foreach (DATA_PIDS[i]) begin
      build_data(DATA_PIDS[i], i, 0);
      send_frame(0);
    end
    // truncated CRC, then corrupted payload
    build_data(PID_DAT0, 0, 0);
    void'(frame.pop_back());
    send_frame(0);
    build_data(PID_DAT1, 3, 0);
    frame[2] = frame[2] ^ 8'h01;
    send_frame(0);
  endtask

  task automatic test_odd_pids;
    build_other(PID_ACK, 0);
    send_frame(0);
    build_other(PID_RSVD, 1);
    send_frame(0);
    build_other(PID_ACK, 0);
    frame[1] = 8'h5a;
    send_frame(0);
    begin_frame(PID_OUT);
    send_frame(0);
    build_other(PID_ACK, 0);
    frame[0] = sync_pattern(!full_speed_cfg);
    send_frame(0);
  endtask

  task automatic test_stuffing;
    build_data(PID_DAT1, 3, 2);
    send_frame(0);
    // stuffed bit arrives as a one
    stuff_fault = 1'b1;
    build_data(PID_DAT0, 2, 2);
    send_frame(0);
    // six ones close the packet, so the marked bit is the stuffed one
    build_other(PID_ACK, 0);
    frame.push_back(8'hfc);
    send_frame(0);
  endtask

  task automatic test_idle_level_mid_packet;
    build_data(PID_DAT1, 2, 1);
    start_packet();
    put_frame_bits(0, 12);
    send_line(1'b0);
    settle();
    write_cfg(CFG_IDLE_LEVEL, !idle_level_cfg);
    enc_level = idle_level_cfg;
    put_frame_bits(12, frame.size() * 8);
    send_line(1'b1);
    settle();
    write_cfg(CFG_IDLE_LEVEL, !idle_level_cfg);
  endtask

  task automatic test_backpressure;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req++;
    build_data(PID_DAT1, 6, 1);
    send_frame(0);
    build_token(PID_IN);
    send_frame(0);
    settle();
  endtask

  task automatic send_random_packet;
    int pick;
    int extra;
    int idx;
    pick = $urandom_range(0, 19);
    extra = 0;
    if (pick >= 17) begin
      // line noise, closed by a marked bit
      start_packet();
      repeat ($urandom_range(1, 40)) line_q.push_back(1'($urandom_range(0, 1)));
      send_line(1'b1);
    end else begin
      if (pick < 7) build_token(TOKEN_PIDS[$urandom_range(0, 5)]);
      else if (pick < 14) build_data(DATA_PIDS[$urandom_range(0, 3)], $urandom_range(0, 8),
                                     $urandom_range(0, 2));
      else build_other(4'($urandom_range(0, 15)), $urandom_range(0, 3));
      case ($urandom_range(0, 15))
        0: begin
          idx = $urandom_range(0, frame.size() - 1);
          frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: void'(frame.pop_back());
        2: extra = $urandom_range(1, 7);
        3: frame[0] = sync_pattern(!full_speed_cfg);
        4: stuff_fault = 1'b1;
        default: ;
      endcase
      send_frame(extra);
    end
  endtask

  task automatic test_random;
    int target;
    logic fast;
    logic idle_hi;
    for (int p = 0; p < 4; p++) begin
      fast = (p == 0 || p == 3);
      idle_hi = (p == 0 || p == 2);
      settle();
      write_cfg(CFG_FULL_SPEED, fast);
      write_cfg(CFG_IDLE_LEVEL, idle_hi);
      tx_idle_on = (p != 1);
      rx_idle_on = (p != 2);
      target = bits_sent + RANDOM_BITS / 5;
      while (bits_sent < target) send_random_packet();
    end
  endtask

  task automatic test_final_stretch;
    int target;
    settle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_cfg(CFG_FULL_SPEED, 1'b1);
    write_cfg(CFG_IDLE_LEVEL, 1'b1);
    target = bits_sent + RANDOM_BITS / 5;
    while (bits_sent < target) send_random_packet();
  endtask

  initial begin
    reset_decode();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_short_packets();
    test_token_packets();
    test_data_packets();
    test_odd_pids();
    test_stuffing();
    test_idle_level_mid_packet();
    test_backpressure();
    test_random();
    test_final_stretch();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: usb_packet_bit_decoder.f
hw/rtl/usbpd_pkg.sv
hw/rtl/usb_packet_bit_decoder.sv
test/usb_packet_bit_decoder_tb.sv
